// ===== design/tmr_pkg.sv =====
// Shared types, codes and constants of the tile map pixel renderer.
package tmr_pkg;

	// Default sizes of the stores.
	localparam int TMR_MAP_DIM     = 64;
	localparam int TMR_FRAME_DIM   = 64;
	localparam int TMR_FRAME_SLOTS = 32;
	localparam int TMR_TILE_MAX    = 64;

	// Fixed field widths and internal depths.
	localparam int COORD_W     = 12;
	localparam int TS_W        = 7;
	localparam int DIV_BPS     = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 32;

	// Tile byte and frame pixel codes.
	localparam logic [7:0] TRANSPARENT_IDX = 8'hFD;
	localparam logic [4:0] ID_SKIP         = 5'd16;
	localparam int         RIVER_BIT       = 5;

	typedef enum logic [2:0] {
		REQ_TILE   = 3'd0,
		REQ_PIX    = 3'd1,
		REQ_SIZE   = 3'd2,
		REQ_PAL    = 3'd3,
		REQ_RENDER = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		CFG_TILE_SIZE   = 3'd0,
		CFG_MAP_WIDTH   = 3'd1,
		CFG_MAP_HEIGHT  = 3'd2,
		CFG_FRAME_COUNT = 3'd3
	} cfg_idx_t;

	// Configuration after clamping to the store limits.
	typedef struct packed {
		logic [6:0] ts;
		logic [6:0] mw;
		logic [6:0] mh;
		logic [5:0] nf;
	} cfg_t;

	// One classified item as it travels from front to back.
	typedef struct packed {
		req_t        kind;
		logic        in_img;
		logic [4:0]  slot;
		logic [11:0] col;
		logic [11:0] row;
		logic [23:0] data;
	} item_t;

	// One rendered pixel, red in the lowest bits.
	typedef struct packed {
		logic       in_bounds;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} res_t;

endpackage

// ===== design/tmr_ram.sv =====
// Generic single write, single read RAM with registered read data.
module tmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/tmr_fifo.sv =====
// Register-based first-in first-out queue with an occupancy count.
module tmr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               push_data,
	input  logic                           pop,
	output logic [WIDTH-1:0]               pop_data,
	output logic [$clog2(DEPTH+1)-1:0]     count,
	output logic                           full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_q];
	assign count    = cnt_q;
	assign full     = (cnt_q == CW'(DEPTH));

endmodule

// ===== design/tmr_div.sv =====
// Pipelined restoring divider that settles BPS quotient bits per stage.
module tmr_div #(
	parameter int NW  = 12,
	parameter int DW  = 7,
	parameter int BPS = 2
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int ST = (NW + BPS - 1) / BPS;
	localparam int PW = ST * BPS;

	logic [PW-1:0] n_q [ST];
	logic [PW-1:0] q_q [ST];
	logic [DW-1:0] r_q [ST];
	logic [DW-1:0] d_q [ST];

	genvar s;
	for (s = 0; s < ST; s++) begin : g_st
		logic [PW-1:0] n_in;
		logic [PW-1:0] q_in;
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [PW-1:0] n_nx;
		logic [PW-1:0] q_nx;
		logic [DW-1:0] r_nx;
		logic [DW:0]   t;

		if (s == 0) begin : g_first
			assign n_in = PW'(num);
			assign q_in = '0;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign n_in = n_q[s-1];
			assign q_in = q_q[s-1];
			assign r_in = r_q[s-1];
			assign d_in = d_q[s-1];
		end

		// Shift in one numerator bit at a time and subtract where it fits.
		always_comb begin
			n_nx = n_in;
			q_nx = q_in;
			r_nx = r_in;
			t    = '0;
			for (int b = 0; b < BPS; b++) begin
				t    = {r_nx, n_nx[PW-1]};
				n_nx = n_nx << 1;
				if (t >= {1'b0, d_in}) begin
					r_nx = DW'(t - {1'b0, d_in});
					q_nx = PW'({q_nx, 1'b1});
				end else begin
					r_nx = t[DW-1:0];
					q_nx = PW'({q_nx, 1'b0});
				end
			end
		end

		always_ff @(posedge clk) begin
			n_q[s] <= n_nx;
			q_q[s] <= q_nx;
			r_q[s] <= r_nx;
			d_q[s] <= d_in;
		end
	end

	assign quo = q_q[ST-1][NW-1:0];
	assign rem = r_q[ST-1];

endmodule

// ===== design/tmr_front.sv =====
// Front end: configuration registers, item decode, range checks and image bounds.
module tmr_front import tmr_pkg::*; #(
	parameter int MAP_DIM     = TMR_MAP_DIM,
	parameter int FRAME_DIM   = TMR_FRAME_DIM,
	parameter int FRAME_SLOTS = TMR_FRAME_SLOTS,
	parameter int TILE_MAX    = TMR_TILE_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_tvalid,
	output logic        in_tready,
	input  logic [2:0]  in_tuser,
	input  logic [55:0] in_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output cfg_t        cfg,
	output logic        q_push,
	output item_t       q_item,
	input  logic        q_full
);

	logic [6:0]  ts_q;
	logic [6:0]  mw_q;
	logic [6:0]  mh_q;
	logic [5:0]  nf_q;
	logic [4:0]  slot;
	logic [11:0] col;
	logic [11:0] row;
	logic [23:0] data;
	logic [13:0] mw_px;
	logic [13:0] mh_px;
	logic        keep;
	logic        inside_px;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= 7'd16;
			mw_q <= 7'd64;
			mh_q <= 7'd64;
			nf_q <= 6'd0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TILE_SIZE:   ts_q <= cfg_data[6:0];
				CFG_MAP_WIDTH:   mw_q <= cfg_data[6:0];
				CFG_MAP_HEIGHT:  mh_q <= cfg_data[6:0];
				CFG_FRAME_COUNT: nf_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Values above the store limits act as the limits.
	assign cfg.ts = (int'(ts_q) > TILE_MAX) ? 7'(TILE_MAX) : ts_q;
	assign cfg.mw = (int'(mw_q) > MAP_DIM) ? 7'(MAP_DIM) : mw_q;
	assign cfg.mh = (int'(mh_q) > MAP_DIM) ? 7'(MAP_DIM) : mh_q;
	assign cfg.nf = (int'(nf_q) > FRAME_SLOTS) ? 6'(FRAME_SLOTS) : nf_q;

	// Unpack the item.
	assign slot = in_tdata[4:0];
	assign col  = in_tdata[16:5];
	assign row  = in_tdata[28:17];
	assign data = in_tdata[52:29];

	// Image bounds in pixels.
	assign mw_px     = 14'(cfg.mw) * 14'(cfg.ts);
	assign mh_px     = 14'(cfg.mh) * 14'(cfg.ts);
	assign inside_px = (cfg.ts != '0) && (14'(col) < mw_px) && (14'(row) < mh_px);

	// Writes that miss their store and unknown requests are dropped here.
	always_comb begin
		case (req_t'(in_tuser))
			REQ_TILE:   keep = (int'(col) < MAP_DIM) && (int'(row) < MAP_DIM);
			REQ_PIX:    keep = (int'(slot) < FRAME_SLOTS) && (int'(col) < FRAME_DIM) &&
			                   (int'(row) < FRAME_DIM);
			REQ_SIZE:   keep = (int'(slot) < FRAME_SLOTS);
			REQ_PAL:    keep = (int'(col) < 256);
			REQ_RENDER: keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	assign in_tready     = !q_full;
	assign q_push        = in_tvalid && in_tready && keep;
	assign q_item.kind   = req_t'(in_tuser);
	assign q_item.in_img = (req_t'(in_tuser) == REQ_RENDER) && inside_px;
	assign q_item.slot   = slot;
	assign q_item.col    = col;
	assign q_item.row    = row;
	assign q_item.data   = data;

endmodule

// ===== design/tmr_back.sv =====
// Back end: tile lookup, frame scaling, frame and palette reads, result queue.
module tmr_back import tmr_pkg::*; #(
	parameter int MAP_DIM     = TMR_MAP_DIM,
	parameter int FRAME_DIM   = TMR_FRAME_DIM,
	parameter int FRAME_SLOTS = TMR_FRAME_SLOTS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	localparam int TA_W = (MAP_DIM * MAP_DIM > 1) ? $clog2(MAP_DIM * MAP_DIM) : 1;
	localparam int FW_W = $clog2(FRAME_DIM + 1);
	localparam int SNW  = TS_W + FW_W;
	localparam int SL_W = $clog2(FRAME_SLOTS);
	localparam int FA_W = $clog2(FRAME_SLOTS * FRAME_DIM * FRAME_DIM);
	localparam int DL1  = (COORD_W + DIV_BPS - 1) / DIV_BPS;
	localparam int DL2  = (SNW + DIV_BPS - 1) / DIV_BPS;
	localparam int CW   = $clog2(OUT_DEPTH + 1);
	localparam logic [FA_W-1:0] FD1 = FA_W'(FRAME_DIM);
	localparam logic [FA_W-1:0] FD2 = FA_W'(FRAME_DIM * FRAME_DIM);

	typedef struct packed {
		item_t            item;
		logic [TS_W-1:0]  ox;
		logic [TS_W-1:0]  oy;
	} s1_t;

	typedef struct packed {
		item_t            item;
		logic             draw;
		logic             river;
		logic             ok0;
		logic             ok1;
		logic [4:0]       id;
		logic [FW_W-1:0]  fw0;
		logic [FW_W-1:0]  fh0;
		logic [FW_W-1:0]  fw1;
		logic [FW_W-1:0]  fh1;
	} s2_t;

	typedef struct packed {
		item_t item;
		logic  draw;
		logic  river;
		logic  ok0;
		logic  ok1;
	} s3_t;

	typedef struct packed {
		item_t item;
		logic  t0;
		logic  t1;
	} s4_t;

	// Issue control: an item enters only when the result queue can take it.
	logic [CW-1:0] inflight_q;
	logic [CW-1:0] out_count;
	logic          credit;
	logic          exit_g;

	assign credit = ({1'b0, inflight_q} + {1'b0, out_count}) < (CW+1)'(OUT_DEPTH);
	assign q_pop  = q_valid && credit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (q_pop && !exit_g) begin
			inflight_q <= inflight_q + CW'(1);
		end else if (exit_g && !q_pop) begin
			inflight_q <= inflight_q - CW'(1);
		end
	end

	// Tile position and offset inside the tile.
	logic [COORD_W-1:0] tx;
	logic [COORD_W-1:0] ty;
	logic [TS_W-1:0]    ox;
	logic [TS_W-1:0]    oy;

	tmr_div #(.NW(COORD_W), .DW(TS_W), .BPS(DIV_BPS)) u_div_x (
		.clk (clk), .num (q_item.col), .den (cfg.ts), .quo (tx), .rem (ox)
	);

	tmr_div #(.NW(COORD_W), .DW(TS_W), .BPS(DIV_BPS)) u_div_y (
		.clk (clk), .num (q_item.row), .den (cfg.ts), .quo (ty), .rem (oy)
	);

	item_t dly_a_q   [DL1];
	logic  dly_a_v_q [DL1];
	item_t item_b;
	logic  v_b;

	assign item_b = dly_a_q[DL1-1];
	assign v_b    = dly_a_v_q[DL1-1];

	// Tile store, written and read at the same point of the pipeline.
	logic            tile_we;
	logic [TA_W-1:0] tile_waddr;
	logic [TA_W-1:0] tile_raddr;
	logic [7:0]      tile_rd;

	assign tile_we    = v_b && (item_b.kind == REQ_TILE);
	assign tile_waddr = TA_W'(item_b.row) * TA_W'(MAP_DIM) + TA_W'(item_b.col);
	assign tile_raddr = TA_W'(ty) * TA_W'(MAP_DIM) + TA_W'(tx);

	tmr_ram #(.WIDTH(8), .DEPTH(MAP_DIM * MAP_DIM)) u_tile_ram (
		.clk (clk), .we (tile_we), .waddr (tile_waddr), .wdata (item_b.data[7:0]),
		.raddr (tile_raddr), .rdata (tile_rd)
	);

	s1_t p_s1;
	logic v_s1;

	// Terrain id, skip rules and frame sizes.
	logic [FW_W-1:0] fw_q [FRAME_SLOTS];
	logic [FW_W-1:0] fh_q [FRAME_SLOTS];
	logic [4:0]      id;
	logic [SL_W-1:0] id_ix;
	logic            draw;
	logic            river;
	logic [FW_W-1:0] fw0;
	logic [FW_W-1:0] fh0;
	logic [FW_W-1:0] fw1;
	logic [FW_W-1:0] fh1;
	logic            size_we;
	logic [SL_W-1:0] size_ix;

	assign id    = tile_rd[4:0];
	assign id_ix = id[SL_W-1:0];
	assign draw  = p_s1.item.in_img && (id != '0) && (id != ID_SKIP) && ({1'b0, id} < cfg.nf);
	assign river = tile_rd[RIVER_BIT] && (cfg.nf > 6'd1);
	assign fw0   = fw_q[id_ix];
	assign fh0   = fh_q[id_ix];
	assign fw1   = fw_q[SL_W'(1)];
	assign fh1   = fh_q[SL_W'(1)];

	assign size_we = v_s1 && (p_s1.item.kind == REQ_SIZE);
	assign size_ix = p_s1.item.slot[SL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				fw_q[i] <= '0;
				fh_q[i] <= '0;
			end
		end else if (size_we) begin
			fw_q[size_ix] <= (int'(p_s1.item.col) > FRAME_DIM) ? FW_W'(FRAME_DIM) :
			                 FW_W'(p_s1.item.col);
			fh_q[size_ix] <= (int'(p_s1.item.row) > FRAME_DIM) ? FW_W'(FRAME_DIM) :
			                 FW_W'(p_s1.item.row);
		end
	end

	s2_t            p_s2;
	logic           v_s2;
	logic [SNW-1:0] px0_s2;
	logic [SNW-1:0] py0_s2;
	logic [SNW-1:0] px1_s2;
	logic [SNW-1:0] py1_s2;

	// Nearest-neighbor scaling: offset times frame size over tile size.
	logic [SNW-1:0]  qx0;
	logic [SNW-1:0]  qy0;
	logic [SNW-1:0]  qx1;
	logic [SNW-1:0]  qy1;
	logic [TS_W-1:0] rx0;
	logic [TS_W-1:0] ry0;
	logic [TS_W-1:0] rx1;
	logic [TS_W-1:0] ry1;

	tmr_div #(.NW(SNW), .DW(TS_W), .BPS(DIV_BPS)) u_div_sx0 (
		.clk (clk), .num (px0_s2), .den (cfg.ts), .quo (qx0), .rem (rx0)
	);
	tmr_div #(.NW(SNW), .DW(TS_W), .BPS(DIV_BPS)) u_div_sy0 (
		.clk (clk), .num (py0_s2), .den (cfg.ts), .quo (qy0), .rem (ry0)
	);
	tmr_div #(.NW(SNW), .DW(TS_W), .BPS(DIV_BPS)) u_div_sx1 (
		.clk (clk), .num (px1_s2), .den (cfg.ts), .quo (qx1), .rem (rx1)
	);
	tmr_div #(.NW(SNW), .DW(TS_W), .BPS(DIV_BPS)) u_div_sy1 (
		.clk (clk), .num (py1_s2), .den (cfg.ts), .quo (qy1), .rem (ry1)
	);

	s2_t  dly_b_q   [DL2];
	logic dly_b_v_q [DL2];
	s2_t  e;
	logic v_e;

	assign e   = dly_b_q[DL2-1];
	assign v_e = dly_b_v_q[DL2-1];

	// Clamp the scaled coordinates and form the frame pixel addresses.
	logic [SNW-1:0]  cx0;
	logic [SNW-1:0]  cy0;
	logic [SNW-1:0]  cx1;
	logic [SNW-1:0]  cy1;
	logic            fr_we;
	logic [FA_W-1:0] fr_waddr;
	logic [FA_W-1:0] fr0_raddr;
	logic [FA_W-1:0] fr1_raddr;
	logic [7:0]      fr0_rd;
	logic [7:0]      fr1_rd;

	assign cx0 = (qx0 >= SNW'(e.fw0)) ? SNW'(e.fw0) - SNW'(1) : qx0;
	assign cy0 = (qy0 >= SNW'(e.fh0)) ? SNW'(e.fh0) - SNW'(1) : qy0;
	assign cx1 = (qx1 >= SNW'(e.fw1)) ? SNW'(e.fw1) - SNW'(1) : qx1;
	assign cy1 = (qy1 >= SNW'(e.fh1)) ? SNW'(e.fh1) - SNW'(1) : qy1;

	assign fr_we     = v_e && (e.item.kind == REQ_PIX);
	assign fr_waddr  = FA_W'(e.item.slot) * FD2 + FA_W'(e.item.row) * FD1 + FA_W'(e.item.col);
	assign fr0_raddr = FA_W'(e.id) * FD2 + FA_W'(cy0) * FD1 + FA_W'(cx0);
	assign fr1_raddr = FD2 + FA_W'(cy1) * FD1 + FA_W'(cx1);

	// Two copies of the frame store give the terrain and the river reads.
	tmr_ram #(.WIDTH(8), .DEPTH(FRAME_SLOTS * FRAME_DIM * FRAME_DIM)) u_frame_ram0 (
		.clk (clk), .we (fr_we), .waddr (fr_waddr), .wdata (e.item.data[7:0]),
		.raddr (fr0_raddr), .rdata (fr0_rd)
	);
	tmr_ram #(.WIDTH(8), .DEPTH(FRAME_SLOTS * FRAME_DIM * FRAME_DIM)) u_frame_ram1 (
		.clk (clk), .we (fr_we), .waddr (fr_waddr), .wdata (e.item.data[7:0]),
		.raddr (fr1_raddr), .rdata (fr1_rd)
	);

	s3_t  p_s3;
	logic v_s3;

	// Transparency and palette lookup.
	logic        t0;
	logic        t1;
	logic        pal_we;
	logic [23:0] pal0_rd;
	logic [23:0] pal1_rd;

	assign t0     = p_s3.draw && p_s3.ok0 && (fr0_rd != TRANSPARENT_IDX);
	assign t1     = p_s3.draw && p_s3.river && p_s3.ok1 && (fr1_rd != TRANSPARENT_IDX);
	assign pal_we = v_s3 && (p_s3.item.kind == REQ_PAL);

	tmr_ram #(.WIDTH(24), .DEPTH(256)) u_pal_ram0 (
		.clk (clk), .we (pal_we), .waddr (p_s3.item.col[7:0]), .wdata (p_s3.item.data),
		.raddr (fr0_rd), .rdata (pal0_rd)
	);
	tmr_ram #(.WIDTH(24), .DEPTH(256)) u_pal_ram1 (
		.clk (clk), .we (pal_we), .waddr (p_s3.item.col[7:0]), .wdata (p_s3.item.data),
		.raddr (fr1_rd), .rdata (pal1_rd)
	);

	s4_t  p_s4;
	logic v_s4;

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DL1; k++) begin
				dly_a_v_q[k] <= 1'b0;
			end
			for (int k = 0; k < DL2; k++) begin
				dly_b_v_q[k] <= 1'b0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			dly_a_v_q[0] <= q_pop;
			for (int k = 1; k < DL1; k++) begin
				dly_a_v_q[k] <= dly_a_v_q[k-1];
			end
			dly_b_v_q[0] <= v_s2;
			for (int k = 1; k < DL2; k++) begin
				dly_b_v_q[k] <= dly_b_v_q[k-1];
			end
			v_s1 <= v_b;
			v_s2 <= v_s1;
			v_s3 <= v_e;
			v_s4 <= v_s3;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		dly_a_q[0] <= q_item;
		for (int k = 1; k < DL1; k++) begin
			dly_a_q[k] <= dly_a_q[k-1];
		end
		p_s1.item <= item_b;
		p_s1.ox   <= ox;
		p_s1.oy   <= oy;

		p_s2.item  <= p_s1.item;
		p_s2.draw  <= draw;
		p_s2.river <= river;
		p_s2.ok0   <= (fw0 != '0) && (fh0 != '0);
		p_s2.ok1   <= (fw1 != '0) && (fh1 != '0);
		p_s2.id    <= id;
		p_s2.fw0   <= fw0;
		p_s2.fh0   <= fh0;
		p_s2.fw1   <= fw1;
		p_s2.fh1   <= fh1;
		px0_s2     <= SNW'(p_s1.ox) * SNW'(fw0);
		py0_s2     <= SNW'(p_s1.oy) * SNW'(fh0);
		px1_s2     <= SNW'(p_s1.ox) * SNW'(fw1);
		py1_s2     <= SNW'(p_s1.oy) * SNW'(fh1);

		dly_b_q[0] <= p_s2;
		for (int k = 1; k < DL2; k++) begin
			dly_b_q[k] <= dly_b_q[k-1];
		end

		p_s3.item  <= e.item;
		p_s3.draw  <= e.draw;
		p_s3.river <= e.river;
		p_s3.ok0   <= e.ok0;
		p_s3.ok1   <= e.ok1;

		p_s4.item <= p_s3.item;
		p_s4.t0   <= t0;
		p_s4.t1   <= t1;
	end

	// Final color: river over terrain over black.
	logic        out_push;
	logic [23:0] rgb;
	res_t        res;

	assign exit_g   = v_s4;
	assign out_push = v_s4 && (p_s4.item.kind == REQ_RENDER);
	assign rgb      = p_s4.t1 ? pal1_rd : (p_s4.t0 ? pal0_rd : 24'd0);

	assign res.in_bounds = p_s4.item.in_img;
	assign res.red       = rgb[23:16];
	assign res.green     = rgb[15:8];
	assign res.blue      = rgb[7:0];

	// Result queue toward the output port.
	logic out_full;
	logic out_pop;

	assign out_valid = (out_count != '0);
	assign out_pop   = out_valid && out_ready;

	tmr_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
		.clk (clk), .arst_n (arst_n), .push (out_push), .push_data (res),
		.pop (out_pop), .pop_data (out_res), .count (out_count), .full (out_full)
	);

endmodule

// ===== design/tile_map_pixel_renderer_top.sv =====
// Top level of the tile map pixel renderer.
// The block takes one item per clock on the input stream while the front queue has room
// and returns one pixel per render item on the output stream, in item order; write items
// return nothing. A render result passes through the front queue, two sets of pipelined
// dividers (tile position, six stages, then frame scaling, seven stages), each settling two
// quotient bits per stage, the tile, frame and palette reads and the result queue. Store
// writes pass through the same pipeline, so a render sees every write accepted before it.
// Output stalls are absorbed by a 32-entry result queue; the input is held back only once
// that queue and the pipeline are full. Frame sizes reset to zero at once; no clearing
// pass runs after reset. Configuration writes are taken in any cycle and are meant to be
// issued while the block is idle.
module tile_map_pixel_renderer_top import tmr_pkg::*; #(
	parameter int MAP_DIM     = TMR_MAP_DIM,
	parameter int FRAME_DIM   = TMR_FRAME_DIM,
	parameter int FRAME_SLOTS = TMR_FRAME_SLOTS,
	parameter int TILE_MAX    = TMR_TILE_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_tvalid,
	output logic        in_tready,
	input  logic [55:0] in_tdata,   // frame_index, col, row, data
	input  logic [2:0]  in_tuser,   // req_type
	output logic        out_tvalid,
	input  logic        out_tready,
	output logic [23:0] out_tdata,  // red, green, blue
	output logic [0:0]  out_tuser,  // in_bounds
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cfg_t           cfg;
	logic           q_push;
	item_t          q_in_item;
	item_t          q_out_item;
	logic           q_full;
	logic           q_pop;
	logic [QCW-1:0] q_count;
	res_t           out_res;

	tmr_front #(
		.MAP_DIM (MAP_DIM), .FRAME_DIM (FRAME_DIM),
		.FRAME_SLOTS (FRAME_SLOTS), .TILE_MAX (TILE_MAX)
	) u_front (
		.clk (clk), .arst_n (arst_n),
		.in_tvalid (in_tvalid), .in_tready (in_tready),
		.in_tuser (in_tuser), .in_tdata (in_tdata),
		.cfg_valid (cfg_valid), .cfg_ready (cfg_ready),
		.cfg_index (cfg_index), .cfg_data (cfg_data),
		.cfg (cfg), .q_push (q_push), .q_item (q_in_item), .q_full (q_full)
	);

	// Short queue between the front and the back.
	tmr_fifo #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk (clk), .arst_n (arst_n), .push (q_push), .push_data (q_in_item),
		.pop (q_pop), .pop_data (q_out_item), .count (q_count), .full (q_full)
	);

	tmr_back #(
		.MAP_DIM (MAP_DIM), .FRAME_DIM (FRAME_DIM), .FRAME_SLOTS (FRAME_SLOTS)
	) u_back (
		.clk (clk), .arst_n (arst_n), .cfg (cfg),
		.q_valid (q_count != '0), .q_item (q_out_item), .q_pop (q_pop),
		.out_valid (out_tvalid), .out_ready (out_tready), .out_res (out_res)
	);

	assign out_tdata    = {out_res.blue, out_res.green, out_res.red};
	assign out_tuser[0] = out_res.in_bounds;

endmodule

// ===== design/tmr_checker.sv =====
// Port-level checks of the renderer and their attachment to the top level.
module tmr_checker import tmr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_tvalid,
	input logic        in_tready,
	input logic [2:0]  in_tuser,
	input logic        out_tvalid,
	input logic        out_tready,
	input logic [23:0] out_tdata,
	input logic [0:0]  out_tuser
);

	logic [7:0] pending_q;
	logic       in_render;
	logic       out_take;

	assign in_render = in_tvalid && in_tready && (in_tuser == REQ_RENDER);
	assign out_take  = out_tvalid && out_tready;

	// Render items accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_render && !out_take) begin
			pending_q <= pending_q + 8'd1;
		end else if (out_take && !in_render) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
		else $error("result changed while stalled");

	// No result without an outstanding render item.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid |-> pending_q != 8'd0)
		else $error("result without a render item");

	// A pixel outside the image is black.
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tuser[0] |-> out_tdata == 24'd0)
		else $error("out-of-bounds pixel not black");

endmodule

bind tile_map_pixel_renderer_top tmr_checker u_checker (.*);
